// ===== design/front_coding_word_encoder_defines.svh =====
// Assertion helpers for the front coding word encoder.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef FRONT_CODING_WORD_ENCODER_DEFINES_SVH
`define FRONT_CODING_WORD_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define FCWE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FCWE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fcwe_pkg.sv =====
package fcwe_pkg;

  localparam int unsigned MaxWordLen   = 127;
  localparam int unsigned LenW         = 7;
  localparam int unsigned ByteW        = 8;
  localparam logic [LenW-1:0] WordLenReset = 7'd8;

  // queue between front and back, and result queue (both powers of two)
  localparam int unsigned MidDepth = 2;
  localparam int unsigned OutDepth = 4;

  typedef struct packed {
    logic             first;      // byte opens a word
    logic             have_prev;  // a previous word exists (valid with first)
    logic             last;       // byte closes the word
    logic [LenW-1:0]  pos;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] stored;     // byte of the previous word at pos
  } fcwe_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_count;
    logic             word_end;
  } fcwe_res_t;

endpackage

// ===== design/fcwe_ram.sv =====
module fcwe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 127
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read and write of the same entry return the old value
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fcwe_fifo.sv =====
module fcwe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rp_q];

  always_comb begin
    rp_d  = do_pop  ? PtrW'(rp_q + 1'b1) : rp_q;
    wp_d  = do_push ? PtrW'(wp_q + 1'b1) : wp_q;
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule

// ===== design/fcwe_front.sv =====
module fcwe_front #(
  parameter int unsigned MAX_WORD_LEN = fcwe_pkg::MaxWordLen
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic                           start_list_i,
  input  logic [fcwe_pkg::ByteW-1:0]     in_byte_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fcwe_pkg::LenW-1:0]      cfg_word_length_i,
  output logic                           item_valid_o,
  output fcwe_pkg::fcwe_item_t           item_o,
  input  logic                           item_ready_i
);

  import fcwe_pkg::*;

  localparam int unsigned AddrW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_WORD_LEN);

  logic [LenW-1:0]  wlen_q, len;
  logic [LenW-1:0]  pos_q, pos_d, pos_eff;
  logic             hp_q, hp_d, hp_eff;
  logic [LenW:0]    pos_inc;
  logic             last, accept;

  // stage holding the accepted byte while the store read completes
  logic             s1_v_q, s1_v_d;
  logic             s1_first_q, s1_hp_q, s1_last_q;
  logic [LenW-1:0]  s1_pos_q;
  logic [ByteW-1:0] s1_data_q;
  logic [ByteW-1:0] stored;

  assign cfg_ready_o = 1'b1;
  assign full_o      = s1_v_q & ~item_ready_i;
  assign accept      = push_i & ~full_o;

  always_comb begin
    if (wlen_q == '0) begin
      len = LenW'(1);
    end else if (wlen_q > MaxLen) begin
      len = MaxLen;
    end else begin
      len = wlen_q;
    end
    pos_eff = start_list_i ? '0 : pos_q;
    hp_eff  = start_list_i ? 1'b0 : hp_q;
    pos_inc = (LenW+1)'(pos_eff) + (LenW+1)'(1);
    last    = pos_inc >= {1'b0, len};
    pos_d   = pos_q;
    hp_d    = hp_q;
    if (accept) begin
      pos_d = last ? '0 : pos_inc[LenW-1:0];
      hp_d  = last | hp_eff;
    end
    s1_v_d = accept | (s1_v_q & ~item_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WordLenReset;
      pos_q  <= '0;
      hp_q   <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        wlen_q <= cfg_word_length_i;
      end
      pos_q  <= pos_d;
      hp_q   <= hp_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_first_q <= (pos_eff == '0);
      s1_hp_q    <= hp_eff;
      s1_last_q  <= last;
      s1_pos_q   <= pos_eff;
      s1_data_q  <= in_byte_i;
    end
  end

  // read-modify-write of the previous word: old byte comes back next cycle
  fcwe_ram #(
    .WIDTH(ByteW),
    .DEPTH(MAX_WORD_LEN)
  ) u_prev_word (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(pos_eff[AddrW-1:0]),
    .wdata_i(in_byte_i),
    .re_i   (accept),
    .raddr_i(pos_eff[AddrW-1:0]),
    .rdata_o(stored)
  );

  assign item_valid_o = s1_v_q;

  always_comb begin
    item_o.first     = s1_first_q;
    item_o.have_prev = s1_hp_q;
    item_o.last      = s1_last_q;
    item_o.pos       = s1_pos_q;
    item_o.data      = s1_data_q;
    item_o.stored    = stored;
  end

endmodule

// ===== design/fcwe_back.sv =====
module fcwe_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  fcwe_pkg::fcwe_item_t  item_i,
  output logic                  item_ready_o,
  output logic                  empty_o,
  input  logic                  pop_i,
  output fcwe_pkg::fcwe_res_t   res_o
);

  import fcwe_pkg::*;

  localparam int unsigned PtrW = $clog2(OutDepth);
  localparam int unsigned CntW = $clog2(OutDepth + 1);

  fcwe_res_t       mem_q [OutDepth];
  logic [PtrW-1:0] rp_q, wp_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sm_q;

  logic            take, sm, match, do_pop;
  logic [1:0]      n, push_n;
  fcwe_res_t       r0, r1;

  // take an item only when both of its possible results fit
  assign item_ready_o = (cnt_q <= CntW'(OutDepth - 2));
  assign take         = item_valid_i & item_ready_o;
  assign empty_o      = (cnt_q == '0);
  assign do_pop       = pop_i & ~empty_o;
  assign res_o        = mem_q[rp_q];

  always_comb begin
    sm    = item_i.first ? item_i.have_prev : sm_q;
    match = (item_i.data == item_i.stored);
    n     = 2'd0;
    r0    = '{out_byte: item_i.data, is_count: 1'b0, word_end: item_i.last};
    r1    = '{out_byte: item_i.data, is_count: 1'b0, word_end: item_i.last};
    if (sm) begin
      if (match) begin
        // byte matches the previous word so far: only the last byte queues a count
        n  = item_i.last ? 2'd1 : 2'd0;
        r0 = '{out_byte: ByteW'({1'b0, item_i.pos} + 1'b1), is_count: 1'b1,
               word_end: 1'b1};
      end else begin
        n  = 2'd2;
        r0 = '{out_byte: ByteW'(item_i.pos), is_count: 1'b1, word_end: 1'b0};
      end
    end else begin
      n = 2'd1;
    end
    push_n = take ? n : 2'd0;
    cnt_d  = cnt_q + CntW'(push_n) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
      sm_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wp_q  <= PtrW'(wp_q + PtrW'(push_n));
      if (do_pop) begin
        rp_q <= PtrW'(rp_q + 1'b1);
      end
      if (take) begin
        sm_q <= sm & match;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wp_q] <= r0;
    end
    if (push_n == 2'd2) begin
      mem_q[PtrW'(wp_q + 1'b1)] <= r1;
    end
  end

endmodule

// ===== design/front_coding_word_encoder.sv =====
// Channel  | Direction | Handshake          | Beat carries
// ---------+-----------+--------------------+----------------------------------------
// input    | in        | push / full        | start_list_i, in_byte_i
// result   | out       | empty / pop        | out_byte_o, is_prefix_count_o, word_end_o
// config   | in        | cfg_valid_i/ready  | cfg_word_length_i
//
// One input beat per cycle unless full; path: front stage, middle queue, result queue.
// The previous-word store is read and written once per byte (one RAM port pair).
// A byte that yields two results takes two pops to drain; the 4-entry result
// queue and 2-entry middle queue absorb this and stalls on either side.
// Reset clears control state only; the word store is not cleared.
module front_coding_word_encoder #(
  parameter int unsigned MAX_WORD_LEN = fcwe_pkg::MaxWordLen
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       start_list_i,
  input  logic [fcwe_pkg::ByteW-1:0] in_byte_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [fcwe_pkg::ByteW-1:0] out_byte_o,
  output logic                       is_prefix_count_o,
  output logic                       word_end_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [fcwe_pkg::LenW-1:0]  cfg_word_length_i
);

  import fcwe_pkg::*;

  fcwe_item_t fr_item, bk_item;
  logic       fr_valid, mid_full, mid_empty, bk_ready;
  fcwe_res_t  res;

  fcwe_front #(
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .start_list_i     (start_list_i),
    .in_byte_i        (in_byte_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_word_length_i(cfg_word_length_i),
    .item_valid_o     (fr_valid),
    .item_o           (fr_item),
    .item_ready_i     (~mid_full)
  );

  fcwe_fifo #(
    .WIDTH($bits(fcwe_item_t)),
    .DEPTH(MidDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_valid),
    .wdata_i(fr_item),
    .full_o (mid_full),
    .pop_i  (bk_ready),
    .rdata_o(bk_item),
    .empty_o(mid_empty)
  );

  fcwe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(~mid_empty),
    .item_i      (bk_item),
    .item_ready_o(bk_ready),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign out_byte_o        = res.out_byte;
  assign is_prefix_count_o = res.is_count;
  assign word_end_o        = res.word_end;

endmodule

// ===== design/fcwe_checker.sv =====
`include "front_coding_word_encoder_defines.svh"

module fcwe_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       empty,
  input logic                       pop,
  input logic [fcwe_pkg::ByteW-1:0] out_byte_o,
  input logic                       is_prefix_count_o,
  input logic                       word_end_o
);

  // prefix counts never exceed the longest word
  `FCWE_ASSERT_IMP(a_count_range, !empty && is_prefix_count_o, out_byte_o[7] == 1'b0, "count out of range")

  // a count closing a fully matching word covers at least one byte
  `FCWE_ASSERT_IMP(a_full_match_nonzero, !empty && is_prefix_count_o && word_end_o, out_byte_o != 8'd0, "zero count on word end")

  // a mid-word count is queued together with its mismatching byte
  `FCWE_ASSERT_NXT(a_count_then_byte, pop && !empty && is_prefix_count_o && !word_end_o, !empty && !is_prefix_count_o, "count not followed by byte")

  // a waiting result holds until popped
  `FCWE_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_byte_o) && $stable(is_prefix_count_o) && $stable(word_end_o), "result changed while waiting")

endmodule

bind front_coding_word_encoder fcwe_checker u_fcwe_checker (.*);
